// ===== rtl/core/rrbo_pkg.sv =====
`timescale 1ns / 1ps
// Package for the receive ring buffer: field widths, op codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package rrbo_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned AMT_W  = 12;
  localparam int unsigned FILL_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DROP  = 3'd3,
    OP_FLUSH = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SINGLE,
    ST_READ,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;    // capture the accepted item
    logic load_burst;   // latch burst length and start pointer
    logic exec_single;  // push/drop/flush/other, one result
    logic rd_issue;     // read one byte from the store
    logic emit_byte;    // send the byte read last as a result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic burst_zero;   // pop/peek has nothing to return
    logic burst_last;   // byte in flight is the last of the burst
    logic out_free;     // output register can take a result this cycle
  } dp_stat_t;

endpackage

// ===== rtl/core/rrbo_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the receive ring buffer: one item at a time.
// Depends on rrbo_pkg.
module rrbo_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrbo_pkg::dp_stat_t  stat_i,
  output rrbo_pkg::ctrl_cmd_t cmd_o
);
  import rrbo_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((stat_i.op == OP_POP || stat_i.op == OP_PEEK) && !stat_i.burst_zero) begin
          cmd_o.load_burst = 1'b1;
          state_d          = ST_READ;
        end else begin
          state_d = ST_SINGLE;
        end
      end
      ST_SINGLE: begin
        if (stat_i.out_free) begin
          cmd_o.exec_single = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          state_d         = stat_i.burst_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/rrbo_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the receive ring buffer: item registers, pointers, byte store
// and output register. Depends on rrbo_pkg; driven by rrbo_ctrl.
module rrbo_dp #(
  parameter int unsigned DEPTH     = 2048,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rrbo_pkg::ctrl_cmd_t                 cmd_i,
  output rrbo_pkg::dp_stat_t                  stat_o,
  input  logic [rrbo_pkg::OP_W-1:0]           op_i,
  input  logic [rrbo_pkg::DATA_W-1:0]         data_in_i,
  input  logic [rrbo_pkg::AMT_W-1:0]          amount_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rrbo_pkg::DATA_W-1:0]         data_out_o,
  output logic                                byte_valid_o,
  output logic                                last_o,
  output logic [rrbo_pkg::FILL_W-1:0]         fill_count_o,
  output logic                                overrun_o
);
  import rrbo_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(MAX_BURST + 1);
  localparam int unsigned CW = (PW > AMT_W) ? PW : AMT_W;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    adv = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] data_q;
  logic [AMT_W-1:0]  amount_q;
  logic [NW-1:0]     n_q;
  logic [PW-1:0]     p_q;
  logic [PW-1:0]     rp_q, wp_q;
  logic [DATA_W-1:0] rd_data_q;
  logic [DATA_W-1:0] mem [DEPTH];

  logic              out_valid_q;
  logic [DATA_W-1:0] data_out_q;
  logic              byte_valid_q, last_q, overrun_q;
  logic [FILL_W-1:0] fill_q;

  logic [PW-1:0]     count;
  logic              full;
  logic [NW-1:0]     amt_cap, burst_n;
  logic [PW-1:0]     drop_n;
  logic [PW:0]       drop_sum;
  logic [PW-1:0]     drop_rp;
  logic [PW-1:0]     single_fill, byte_fill;
  op_e               op;
  logic              mem_we;

  assign op = op_e'(op_q);

  // fill = (wp - rp) mod DEPTH, DEPTH need not be a power of two
  always_comb begin
    if (wp_q >= rp_q) begin
      count = wp_q - rp_q;
    end else begin
      count = PW'((PW+1)'(wp_q) + (PW+1)'(DEPTH) - (PW+1)'(rp_q));
    end
  end

  assign full = (count == PW'(DEPTH - 1));

  // burst length: min(amount, MAX_BURST, fill)
  assign amt_cap = (amount_q > AMT_W'(MAX_BURST)) ? NW'(MAX_BURST) : NW'(amount_q);
  assign burst_n = (CW'(amt_cap) > CW'(count)) ? NW'(count) : amt_cap;

  // drop: min(amount, fill), read pointer moves by that much with wrap
  assign drop_n   = (CW'(amount_q) < CW'(count)) ? PW'(amount_q) : count;
  assign drop_sum = (PW+1)'(rp_q) + (PW+1)'(drop_n);
  assign drop_rp  = (drop_sum >= (PW+1)'(DEPTH)) ? PW'(drop_sum - (PW+1)'(DEPTH))
                                                 : PW'(drop_sum);

  always_comb begin
    unique case (op)
      OP_PUSH:  single_fill = full ? count : count + 1'b1;
      OP_DROP:  single_fill = count - drop_n;
      OP_FLUSH: single_fill = '0;
      default:  single_fill = count;
    endcase
  end

  assign byte_fill = (op == OP_POP) ? count - 1'b1 : count;
  assign mem_we    = cmd_i.exec_single && (op == OP_PUSH);

  assign stat_o.op         = op;
  assign stat_o.burst_zero = (burst_n == '0);
  assign stat_o.burst_last = (n_q == NW'(1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // item capture and burst bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= op_i;
      data_q   <= data_in_i;
      amount_q <= amount_i;
    end
    if (cmd_i.load_burst) begin
      n_q <= burst_n;
      p_q <= rp_q;
    end else if (cmd_i.emit_byte) begin
      n_q <= n_q - 1'b1;
      p_q <= adv(p_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
      wp_q <= '0;
    end else if (cmd_i.exec_single) begin
      unique case (op)
        OP_PUSH: begin
          wp_q <= adv(wp_q);
          if (full) begin
            rp_q <= adv(rp_q);
          end
        end
        OP_DROP:  rp_q <= drop_rp;
        OP_FLUSH: rp_q <= wp_q;
        default:  ;
      endcase
    end else if (cmd_i.emit_byte && op == OP_POP) begin
      rp_q <= adv(rp_q);
    end
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= data_q;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[p_q];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec_single || cmd_i.emit_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_single) begin
      data_out_q   <= '0;
      byte_valid_q <= 1'b0;
      last_q       <= 1'b1;
      fill_q       <= FILL_W'(single_fill);
      overrun_q    <= (op == OP_PUSH) && full;
    end else if (cmd_i.emit_byte) begin
      data_out_q   <= rd_data_q;
      byte_valid_q <= 1'b1;
      last_q       <= (n_q == NW'(1));
      fill_q       <= FILL_W'(byte_fill);
      overrun_q    <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = data_out_q;
  assign byte_valid_o = byte_valid_q;
  assign last_o       = last_q;
  assign fill_count_o = fill_q;
  assign overrun_o    = overrun_q;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((PW+1)'(rp_q) < (PW+1)'(DEPTH)) && ((PW+1)'(wp_q) < (PW+1)'(DEPTH)))
    else $error("ring pointer out of range");

  a_emit_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_byte |-> (n_q != '0))
    else $error("byte emitted past end of burst");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> (count != '0))
    else $error("store read while empty");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec_single && op == OP_FLUSH) |=> (rp_q == wp_q))
    else $error("flush left bytes behind");

endmodule

// ===== rtl/core/receive_ring_buffer_overwrite_core.sv =====
`timescale 1ns / 1ps
// Top level of the receive ring buffer with overwrite of the oldest byte.
// Depends on rrbo_pkg, rrbo_ctrl and rrbo_dp.
//
// Receive byte FIFO on a circular store of DEPTH bytes holding at most
// DEPTH-1 of them. Ops: push (a full store drops its oldest byte and flags
// overrun), pop and peek (up to min(amount, MAX_BURST, fill) bytes, one result
// per byte, last on the final one; nothing to return gives one empty result),
// drop (discards min(amount, fill)), flush, and unused codes that only report.
// Every result carries the fill count after it, truncated to 11 bits.
// One item is in work at a time. Push, drop, flush and unused codes pass decode
// and a result state that waits for a free output register; the next item can
// then be taken. Pop/peek latch the burst, then read and emit each byte in turn
// (emit waits for a free output register), as the byte store has one read port
// with registered read data. A result waiting in the output register does not
// block acceptance of the next item. The store needs no clearing after reset.
module receive_ring_buffer_overwrite_core #(
  parameter int unsigned DEPTH     = 2048,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rrbo_pkg::OP_W-1:0]   op_i,
  input  logic [rrbo_pkg::DATA_W-1:0] data_in_i,
  input  logic [rrbo_pkg::AMT_W-1:0]  amount_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rrbo_pkg::DATA_W-1:0] data_out_o,
  output logic                        byte_valid_o,
  output logic                        last_o,
  output logic [rrbo_pkg::FILL_W-1:0] fill_count_o,
  output logic                        overrun_o
);
  import rrbo_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: accept, decode, then single result or read/emit loop
  rrbo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // pointers, byte store and output register
  rrbo_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (op_i),
    .data_in_i    (data_in_i),
    .amount_i     (amount_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_out_o   (data_out_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .fill_count_o (fill_count_o),
    .overrun_o    (overrun_o)
  );

endmodule

// ===== tb/sv/tb_receive_ring_buffer_overwrite_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for receive_ring_buffer_overwrite_core: a directed table, random
// traffic and a back-to-back push run, scored against an in-bench mirror or typed rows.
// Depends on rrbo_pkg and the core RTL.
module tb_receive_ring_buffer_overwrite_core;
  import rrbo_pkg::*;

  localparam int unsigned DEPTH     = 2048;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned PW        = $clog2(DEPTH);
  // op codes the core does not decode; they only report the fill count
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  localparam int MAX_REPORTS = 60;

  // one result item as seen on the output channel
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              byte_valid;
    logic              last;
    logic [FILL_W-1:0] fill;
    logic              overrun;
  } rx_result_t;

  // one stimulus row; typed rows carry a hand-written single result
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data;
    logic [AMT_W-1:0]  amount;
    logic              typed;
    logic [FILL_W-1:0] typed_fill;
  } stim_row_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic [OP_W-1:0]   item_op     = '0;
  logic [DATA_W-1:0] item_data   = '0;
  logic [AMT_W-1:0]  item_amount = '0;
  logic              out_ready   = 1'b0;

  logic              in_ready;
  logic              out_valid;
  logic [DATA_W-1:0] data_out;
  logic              byte_valid;
  logic              last;
  logic [FILL_W-1:0] fill_count;
  logic              overrun;

  // mirror of the FIFO: byte store plus head (oldest byte) and tail (next free slot)
  logic [DATA_W-1:0] mirror_bytes [DEPTH];
  int unsigned       head_idx = 0;
  int unsigned       tail_idx = 0;

  rx_result_t  pending_results [$];
  stim_row_t   stim_table [$];
  int          errors      = 0;
  int          reports     = 0;
  int          burst_left  = 0;
  bit          tx_no_gap   = 1'b0;
  bit          rx_no_stall = 1'b0;
  int          hold_cnt    = 0;

  receive_ring_buffer_overwrite_core #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (item_op),
    .data_in_i    (item_data),
    .amount_i     (item_amount),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .data_out_o   (data_out),
    .byte_valid_o (byte_valid),
    .last_o       (last),
    .fill_count_o (fill_count),
    .overrun_o    (overrun)
  );

  always #10 clk = ~clk;

  // Hard stop in case the core hangs or drops results.
  initial begin
    #12_000_000;
    $display("tb_receive_ring_buffer_overwrite_core NOT OK");
    $finish;
  end

  function automatic int unsigned fifo_level();
    return (tail_idx + DEPTH - head_idx) % DEPTH;
  endfunction

  function automatic void queue_result(input logic [DATA_W-1:0] d, input logic bv,
                                       input logic lst, input int unsigned lvl,
                                       input logic ovr);
    rx_result_t r;
    r.data       = d;
    r.byte_valid = bv;
    r.last       = lst;
    r.fill       = lvl[FILL_W-1:0];
    r.overrun    = ovr;
    pending_results.push_back(r);
  endfunction

  // Advances the mirror by one accepted item and queues every result it causes.
  function automatic void fifo_apply(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] d,
                                     input logic [AMT_W-1:0] amt);
    int unsigned lvl;
    int unsigned n;
    int unsigned p;
    logic        ovr;
    lvl = fifo_level();
    case (op)
      OP_PUSH: begin
        mirror_bytes[PW'(tail_idx)] = d;
        tail_idx = (tail_idx + 1) % DEPTH;
        // tail caught the head: oldest byte is lost
        ovr = (tail_idx == head_idx);
        if (ovr) head_idx = (head_idx + 1) % DEPTH;
        queue_result('0, 1'b0, 1'b1, fifo_level(), ovr);
      end
      OP_POP, OP_PEEK: begin
        n = 32'(amt);
        if (n > MAX_BURST) n = MAX_BURST;
        if (n > lvl) n = lvl;
        if (n == 0) queue_result('0, 1'b0, 1'b1, lvl, 1'b0);
        p = head_idx;
        for (int i = 0; i < n; i++) begin
          d = mirror_bytes[PW'(p)];
          p = (p + 1) % DEPTH;
          if (op == OP_POP) begin
            head_idx = p;
            queue_result(d, 1'b1, i == n - 1, fifo_level(), 1'b0);
          end else begin
            queue_result(d, 1'b1, i == n - 1, lvl, 1'b0);
          end
        end
      end
      OP_DROP: begin
        n = (32'(amt) < lvl) ? 32'(amt) : lvl;
        head_idx = (head_idx + n) % DEPTH;
        queue_result('0, 1'b0, 1'b1, fifo_level(), 1'b0);
      end
      OP_FLUSH: begin
        head_idx = tail_idx;
        queue_result('0, 1'b0, 1'b1, 0, 1'b0);
      end
      default: queue_result('0, 1'b0, 1'b1, lvl, 1'b0);
    endcase
  endfunction

  function automatic stim_row_t mk_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] d,
                                       input logic [AMT_W-1:0] amt, input logic typed,
                                       input logic [FILL_W-1:0] tfill);
    stim_row_t r;
    r.op         = op;
    r.data       = d;
    r.amount     = amt;
    r.typed      = typed;
    r.typed_fill = tfill;
    return r;
  endfunction

  // Push-heavy mix so the store holds bytes; amounts mostly small, a few saturating.
  function automatic stim_row_t random_row();
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [AMT_W-1:0]  amt;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = OP_PUSH;
    else if (pick < 65) op = OP_POP;
    else if (pick < 80) op = OP_PEEK;
    else if (pick < 90) op = OP_DROP;
    else if (pick < 93) op = OP_FLUSH;
    else                op = OP_W'($urandom_range(32'(OP_RSVD5), 32'(OP_RSVD7)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: amt = AMT_W'($urandom_range(0, 8));
      6, 7:             amt = AMT_W'($urandom_range(0, 80));
      8:                amt = ($urandom_range(0, 1) != 0) ? 12'd2048 : 12'd2047;
      default:          amt = AMT_W'($urandom_range(0, 2048));
    endcase
    return mk_row(op, DATA_W'($urandom_range(0, 255)), amt, 1'b0, '0);
  endfunction

  // Sender works in bursts; between bursts valid drops for a random gap.
  task automatic pace_sender();
    int gap;
    if (tx_no_gap || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 9);
    end
  endtask

  // Called on a rising edge. Holds the item until the core takes it, then scores it.
  task automatic send_item(input stim_row_t row);
    rx_result_t typed_res;
    item_op     <= row.op;
    item_data   <= row.data;
    item_amount <= row.amount;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    fifo_apply(row.op, row.data, row.amount);
    if (row.typed) begin
      // the mirror still tracks state; the check uses the hand-written result
      pending_results.delete(pending_results.size() - 1);
      typed_res = '{data: '0, byte_valid: 1'b0, last: 1'b1, fill: row.typed_fill,
                    overrun: 1'b0};
      pending_results.push_back(typed_res);
    end
    pace_sender();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    errors++;
    if (reports < MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    reports++;
  endtask

  // Receiver: ready held for random stretches, low about a third of the time.
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_ready <= rx_no_stall ? 1'b1 : ($urandom_range(0, 2) != 0);
      hold_cnt  <= $urandom_range(0, 7);
    end
  end

  // Scoreboard: every output handshake is matched against the oldest expectation.
  always @(posedge clk) begin : score_results
    rx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS)
          $display("%0t ns: result with nothing pending, expected none, got data %0h fill %0d",
                   $time, data_out, fill_count);
        reports++;
      end else begin
        want = pending_results.pop_front();
        if (data_out !== want.data)
          note_mismatch("data_out", 32'(want.data), 32'(data_out));
        if (byte_valid !== want.byte_valid)
          note_mismatch("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
        if (last !== want.last)
          note_mismatch("last", 32'(want.last), 32'(last));
        if (fill_count !== want.fill)
          note_mismatch("fill_count", 32'(want.fill), 32'(fill_count));
        if (overrun !== want.overrun)
          note_mismatch("overrun", 32'(want.overrun), 32'(overrun));
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Typed rows give the single result expected; the rest use the mirror.
    // empty store: nothing to return, nothing to drop
    stim_table.push_back(mk_row(OP_POP,   8'h00, 12'd5,    1'b1, 11'd0));
    stim_table.push_back(mk_row(OP_PEEK,  8'h00, 12'd2048, 1'b1, 11'd0));
    stim_table.push_back(mk_row(OP_DROP,  8'h00, 12'd2048, 1'b1, 11'd0));
    stim_table.push_back(mk_row(OP_FLUSH, 8'h00, 12'd0,    1'b1, 11'd0));
    stim_table.push_back(mk_row(OP_RSVD5, 8'hFF, 12'd4095, 1'b1, 11'd0));
    // data extremes
    stim_table.push_back(mk_row(OP_PUSH,  8'h00, 12'd0,    1'b1, 11'd1));
    stim_table.push_back(mk_row(OP_PUSH,  8'hFF, 12'd4095, 1'b1, 11'd2));
    stim_table.push_back(mk_row(OP_PUSH,  8'hA5, 12'd0,    1'b1, 11'd3));
    stim_table.push_back(mk_row(OP_PUSH,  8'h5A, 12'd0,    1'b1, 11'd4));
    // zero amount on a non-empty store
    stim_table.push_back(mk_row(OP_PEEK,  8'h00, 12'd0,    1'b1, 11'd4));
    stim_table.push_back(mk_row(OP_PEEK,  8'h00, 12'd2,    1'b0, 11'd0));
    stim_table.push_back(mk_row(OP_POP,   8'h00, 12'd1,    1'b0, 11'd0));
    stim_table.push_back(mk_row(OP_RSVD6, 8'h00, 12'd0,    1'b1, 11'd3));
    // amount above the fill count
    stim_table.push_back(mk_row(OP_POP,   8'h00, 12'd2048, 1'b0, 11'd0));
    stim_table.push_back(mk_row(OP_POP,   8'h00, 12'd1,    1'b1, 11'd0));
    stim_table.push_back(mk_row(OP_PUSH,  8'h11, 12'd0,    1'b1, 11'd1));
    stim_table.push_back(mk_row(OP_PUSH,  8'h22, 12'd0,    1'b1, 11'd2));
    stim_table.push_back(mk_row(OP_PUSH,  8'h33, 12'd0,    1'b1, 11'd3));
    stim_table.push_back(mk_row(OP_PUSH,  8'h44, 12'd0,    1'b1, 11'd4));
    stim_table.push_back(mk_row(OP_PUSH,  8'h55, 12'd0,    1'b1, 11'd5));
    stim_table.push_back(mk_row(OP_DROP,  8'h00, 12'd2,    1'b1, 11'd3));
    stim_table.push_back(mk_row(OP_POP,   8'h00, 12'd0,    1'b1, 11'd3));
    stim_table.push_back(mk_row(OP_RSVD7, 8'h00, 12'd7,    1'b1, 11'd3));
    // drop saturates at the fill count
    stim_table.push_back(mk_row(OP_DROP,  8'h00, 12'd2048, 1'b1, 11'd0));
    stim_table.push_back(mk_row(OP_PUSH,  8'h80, 12'd0,    1'b1, 11'd1));
    stim_table.push_back(mk_row(OP_FLUSH, 8'h00, 12'd0,    1'b1, 11'd0));
    foreach (stim_table[i]) send_item(stim_table[i]);

    // random traffic, first half
    repeat (30) send_item(random_row());

    // Back-to-back pushes so the store holds more than one full burst.
    tx_no_gap = 1'b1;
    for (int i = 0; i < 70; i++)
      send_item(mk_row(OP_PUSH, DATA_W'($urandom_range(0, 255)),
                       AMT_W'($urandom_range(0, 4095)), 1'b0, '0));
    send_item(mk_row(OP_PEEK, 8'h00, 12'd65,   1'b0, '0));  // burst cap
    send_item(mk_row(OP_POP,  8'h00, 12'd2048, 1'b0, '0));
    repeat (3) send_item(mk_row(OP_PUSH, DATA_W'($urandom_range(0, 255)), 12'd0, 1'b0, '0));
    send_item(mk_row(OP_POP,  8'h00, 12'd0,    1'b0, '0));
    send_item(mk_row(OP_DROP, 8'h00, 12'd2048, 1'b0, '0));  // drop above the fill count
    repeat (5) send_item(mk_row(OP_PUSH, DATA_W'($urandom_range(0, 255)), 12'd0, 1'b0, '0));
    tx_no_gap = 1'b0;

    // let the core run dry before going on
    wait_drained();
    @(posedge clk);

    // random traffic, second half, with a stretch where neither side idles
    for (int i = 0; i < 30; i++) begin
      rx_no_stall <= (i >= 10 && i < 20);
      tx_no_gap = (i >= 10 && i < 20);
      send_item(random_row());
    end
    rx_no_stall <= 1'b0;

    // catch any stray result after the last expected one
    wait_drained();
    repeat (2 * MAX_BURST + 20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_receive_ring_buffer_overwrite_core OK");
    end else begin
      $display("tb_receive_ring_buffer_overwrite_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rrbo_pkg.sv
rtl/core/rrbo_ctrl.sv
rtl/core/rrbo_dp.sv
rtl/core/receive_ring_buffer_overwrite_core.sv
tb/sv/tb_receive_ring_buffer_overwrite_core.sv
